// ===== design/segment_intersection_macros.svh =====
// Assertion macros for the segment crossing unit.
// Used by the port checker; expects aclk and aresetn in scope.
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// Clocked check, masked while reset is held.
`define SEGX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked check that also runs through reset.
`define SEGX_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ===== design/segx_pkg.sv =====
// Shared widths, types and codes of the segment crossing unit.
// No dependencies; every design file but the macro header refers to it by scoped names.
package segx_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;

    localparam int DX_W        = COORD_BITS + 1;
    localparam int PROD_W      = 2 * COORD_BITS;
    localparam int CR_W        = PROD_W + 1;
    localparam int PD_W        = 2 * DX_W;
    localparam int DEN_W       = PD_W + 1;
    localparam int NP_W        = CR_W + DX_W;
    localparam int NUM_W       = NP_W + 1;
    localparam int QUO_W       = COORD_BITS + FRAC_BITS;
    localparam int MAG_W       = NUM_W + FRAC_BITS;
    localparam int HI_W        = MAG_W - QUO_W;
    localparam int REM_W       = DEN_W + 1;
    localparam int PX_W        = QUO_W + 1;
    localparam int OUT_W       = 32;
    localparam int SAT_W       = (PX_W > OUT_W) ? PX_W : OUT_W + 1;
    localparam int IN_FIELDS   = 8;
    localparam int IN_TDATA_W  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * OUT_W;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [OUT_TUSER_W-1:0] {
        OUT_HIT      = 2'd0,
        OUT_MISS     = 2'd1,
        OUT_PARALLEL = 2'd2
    } outcome_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t lo;
        coord_t hi;
    } span_t;

    // One axis of a word in flight through the divider.
    typedef struct packed {
        logic             zero;
        logic             neg;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] qm;
        logic [DEN_W-1:0] dmag;
        span_t            span_a;
        span_t            span_b;
    } divw_t;

    typedef struct packed {
        outcome_t         outcome;
        logic [OUT_W-1:0] cross_y;
        logic [OUT_W-1:0] cross_x;
    } res_t;

endpackage

// ===== design/segx_front.sv =====
// Front end of the segment crossing unit: differences, cross products,
// denominator, numerators and divider setup in five register stages. Uses segx_pkg.
module segx_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             s_valid,
    input  logic [segx_pkg::IN_TDATA_W-1:0]  s_data,
    output logic                             out_valid,
    output segx_pkg::divw_t                  x_out,
    output segx_pkg::divw_t                  y_out
);

    typedef struct packed {
        segx_pkg::span_t ax;
        segx_pkg::span_t ay;
        segx_pkg::span_t bx;
        segx_pkg::span_t by;
    } box_t;

    segx_pkg::coord_t x1, y1, x2, y2, x3, y3, x4, y4;

    assign x1 = s_data[0*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];
    assign y1 = s_data[1*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];
    assign x2 = s_data[2*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];
    assign y2 = s_data[3*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];
    assign x3 = s_data[4*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];
    assign y3 = s_data[5*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];
    assign x4 = s_data[6*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];
    assign y4 = s_data[7*segx_pkg::COORD_BITS +: segx_pkg::COORD_BITS];

    logic [4:0] v_reg;
    logic [4:0] v_next;

    // stage 1
    logic signed [segx_pkg::PROD_W-1:0] p12a_reg, p12b_reg, p34a_reg, p34b_reg;
    logic signed [segx_pkg::DX_W-1:0]   dx12_reg, dy12_reg, dx34_reg, dy34_reg;
    box_t                               box1_reg, box1_next;
    // stage 2
    logic signed [segx_pkg::CR_W-1:0]   c12_reg, c34_reg;
    logic signed [segx_pkg::PD_W-1:0]   pd1_reg, pd2_reg;
    logic signed [segx_pkg::DX_W-1:0]   dx12b_reg, dy12b_reg, dx34b_reg, dy34b_reg;
    box_t                               box2_reg;
    // stage 3
    logic signed [segx_pkg::DEN_W-1:0]  den3_reg;
    logic signed [segx_pkg::NP_W-1:0]   pn1_reg, pn2_reg, pn3_reg, pn4_reg;
    box_t                               box3_reg;
    // stage 4
    logic signed [segx_pkg::DEN_W-1:0]  den4_reg;
    logic signed [segx_pkg::NUM_W-1:0]  nx_reg, ny_reg;
    box_t                               box4_reg;
    // stage 5
    segx_pkg::divw_t                    x_reg, y_reg, x_next, y_next;

    function automatic segx_pkg::span_t mk_span(segx_pkg::coord_t a, segx_pkg::coord_t b);
        segx_pkg::span_t s;
        s.lo = (a < b) ? a : b;
        s.hi = (a < b) ? b : a;
        return s;
    endfunction

    function automatic segx_pkg::divw_t mk_div(logic signed [segx_pkg::NUM_W-1:0] n,
                                              logic signed [segx_pkg::DEN_W-1:0] d,
                                              segx_pkg::span_t sa, segx_pkg::span_t sb);
        segx_pkg::divw_t            w;
        logic [segx_pkg::NUM_W-1:0] an;
        logic [segx_pkg::MAG_W-1:0] m;
        an       = n[segx_pkg::NUM_W-1] ? segx_pkg::NUM_W'(-n) : segx_pkg::NUM_W'(n);
        m        = segx_pkg::MAG_W'(an) << segx_pkg::FRAC_BITS;
        w.zero   = (d == '0);
        w.neg    = n[segx_pkg::NUM_W-1] ^ d[segx_pkg::DEN_W-1];
        w.ovf    = 1'b0;
        w.rem    = segx_pkg::REM_W'(m[segx_pkg::MAG_W-1 -: segx_pkg::HI_W]);
        w.qm     = m[segx_pkg::QUO_W-1:0];
        w.dmag   = d[segx_pkg::DEN_W-1] ? segx_pkg::DEN_W'(-d) : segx_pkg::DEN_W'(d);
        w.span_a = sa;
        w.span_b = sb;
        return w;
    endfunction

    always_comb begin
        v_next       = {v_reg[3:0], s_valid};
        box1_next.ax = mk_span(x1, x2);
        box1_next.ay = mk_span(y1, y2);
        box1_next.bx = mk_span(x3, x4);
        box1_next.by = mk_span(y3, y4);
        x_next       = mk_div(nx_reg, den4_reg, box4_reg.ax, box4_reg.bx);
        y_next       = mk_div(ny_reg, den4_reg, box4_reg.ay, box4_reg.by);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p12a_reg  <= segx_pkg::PROD_W'(x1) * segx_pkg::PROD_W'(y2);
            p12b_reg  <= segx_pkg::PROD_W'(y1) * segx_pkg::PROD_W'(x2);
            p34a_reg  <= segx_pkg::PROD_W'(x3) * segx_pkg::PROD_W'(y4);
            p34b_reg  <= segx_pkg::PROD_W'(y3) * segx_pkg::PROD_W'(x4);
            dx12_reg  <= segx_pkg::DX_W'(x1) - segx_pkg::DX_W'(x2);
            dy12_reg  <= segx_pkg::DX_W'(y1) - segx_pkg::DX_W'(y2);
            dx34_reg  <= segx_pkg::DX_W'(x3) - segx_pkg::DX_W'(x4);
            dy34_reg  <= segx_pkg::DX_W'(y3) - segx_pkg::DX_W'(y4);
            box1_reg  <= box1_next;

            c12_reg   <= segx_pkg::CR_W'(p12a_reg) - segx_pkg::CR_W'(p12b_reg);
            c34_reg   <= segx_pkg::CR_W'(p34a_reg) - segx_pkg::CR_W'(p34b_reg);
            pd1_reg   <= segx_pkg::PD_W'(dx12_reg) * segx_pkg::PD_W'(dy34_reg);
            pd2_reg   <= segx_pkg::PD_W'(dy12_reg) * segx_pkg::PD_W'(dx34_reg);
            dx12b_reg <= dx12_reg;
            dy12b_reg <= dy12_reg;
            dx34b_reg <= dx34_reg;
            dy34b_reg <= dy34_reg;
            box2_reg  <= box1_reg;

            den3_reg  <= segx_pkg::DEN_W'(pd1_reg) - segx_pkg::DEN_W'(pd2_reg);
            pn1_reg   <= segx_pkg::NP_W'(c12_reg) * segx_pkg::NP_W'(dx34b_reg);
            pn2_reg   <= segx_pkg::NP_W'(dx12b_reg) * segx_pkg::NP_W'(c34_reg);
            pn3_reg   <= segx_pkg::NP_W'(c12_reg) * segx_pkg::NP_W'(dy34b_reg);
            pn4_reg   <= segx_pkg::NP_W'(dy12b_reg) * segx_pkg::NP_W'(c34_reg);
            box3_reg  <= box2_reg;

            den4_reg  <= den3_reg;
            nx_reg    <= segx_pkg::NUM_W'(pn1_reg) - segx_pkg::NUM_W'(pn2_reg);
            ny_reg    <= segx_pkg::NUM_W'(pn3_reg) - segx_pkg::NUM_W'(pn4_reg);
            box4_reg  <= box3_reg;

            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    assign out_valid = v_reg[4];
    assign x_out     = x_reg;
    assign y_out     = y_reg;

endmodule

// ===== design/segx_div.sv =====
// Restoring divider pipeline for one axis: one quotient bit per stage.
// Uses segx_pkg; instantiated once per axis by the top level.
module segx_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  segx_pkg::divw_t in_word,
    output logic            out_valid,
    output segx_pkg::divw_t out_word
);

    localparam int N = segx_pkg::QUO_W;

    logic [N-1:0]    v_reg;
    logic [N-1:0]    v_next;
    segx_pkg::divw_t st_reg  [N];
    segx_pkg::divw_t st_next [N];
    segx_pkg::divw_t cur     [N];

    // Shift in one dividend bit, subtract when it fits; the first stage
    // also flags a quotient too large for the result range.
    function automatic segx_pkg::divw_t step(segx_pkg::divw_t w, logic first);
        segx_pkg::divw_t            r;
        logic [segx_pkg::REM_W-1:0] rs;
        logic [segx_pkg::REM_W-1:0] dd;
        logic                       ge;
        r  = w;
        dd = segx_pkg::REM_W'(w.dmag);
        rs = {w.rem[segx_pkg::REM_W-2:0], w.qm[segx_pkg::QUO_W-1]};
        ge = (rs >= dd);
        r.rem = ge ? rs - dd : rs;
        r.qm  = {w.qm[segx_pkg::QUO_W-2:0], ge};
        if (first) begin
            r.ovf = (w.rem >= dd);
        end
        return r;
    endfunction

    always_comb begin
        cur[0] = in_word;
        for (int k = 1; k < N; k++) begin
            cur[k] = st_reg[k-1];
        end
        for (int k = 0; k < N; k++) begin
            st_next[k] = step(cur[k], (k == 0));
        end
        v_next = {v_reg[N-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_word  = st_reg[N-1];

endmodule

// ===== design/segx_back.sv =====
// Result stage: range fit, bounding-box test, saturation and the output
// register with its skid word. Uses segx_pkg.
module segx_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            x_valid,
    input  segx_pkg::divw_t x_word,
    input  logic            y_valid,
    input  segx_pkg::divw_t y_word,
    output logic            en,
    output logic            m_valid,
    input  logic            m_ready,
    output segx_pkg::res_t  m_res
);

    typedef struct packed {
        logic                       good;
        logic [segx_pkg::OUT_W-1:0] val;
    } axr_t;

    localparam logic [segx_pkg::QUO_W-1:0] QUO_LIM =
        {1'b1, {(segx_pkg::QUO_W-1){1'b0}}};
    localparam logic signed [segx_pkg::SAT_W-1:0] SAT_MAX =
        {{(segx_pkg::SAT_W-segx_pkg::OUT_W){1'b0}}, 1'b0, {(segx_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [segx_pkg::SAT_W-1:0] SAT_MIN =
        {{(segx_pkg::SAT_W-segx_pkg::OUT_W){1'b1}}, 1'b1, {(segx_pkg::OUT_W-1){1'b0}}};

    function automatic logic signed [segx_pkg::PX_W-1:0] scale(segx_pkg::coord_t c);
        logic signed [segx_pkg::PX_W-1:0] e;
        e = segx_pkg::PX_W'(c);
        return e <<< segx_pkg::FRAC_BITS;
    endfunction

    function automatic axr_t eval(segx_pkg::divw_t w);
        axr_t                             r;
        logic                             fits;
        logic                             in_box;
        logic signed [segx_pkg::PX_W-1:0] mag;
        logic signed [segx_pkg::PX_W-1:0] px;
        logic signed [segx_pkg::SAT_W-1:0] pe;
        fits   = !w.ovf && (w.qm <= QUO_LIM);
        mag    = $signed({1'b0, w.qm});
        px     = w.neg ? -mag : mag;
        in_box = (px >= scale(w.span_a.lo)) && (px <= scale(w.span_a.hi)) &&
                 (px >= scale(w.span_b.lo)) && (px <= scale(w.span_b.hi));
        pe     = segx_pkg::SAT_W'(px);
        if (!fits) begin
            r.val = w.neg ? SAT_MIN[segx_pkg::OUT_W-1:0] : SAT_MAX[segx_pkg::OUT_W-1:0];
        end else if (pe > SAT_MAX) begin
            r.val = SAT_MAX[segx_pkg::OUT_W-1:0];
        end else if (pe < SAT_MIN) begin
            r.val = SAT_MIN[segx_pkg::OUT_W-1:0];
        end else begin
            r.val = pe[segx_pkg::OUT_W-1:0];
        end
        r.good = fits && in_box;
        return r;
    endfunction

    axr_t           ax, ay;
    segx_pkg::res_t res_next;
    logic           in_valid;

    logic           m_valid_reg, sk_valid_reg;
    segx_pkg::res_t m_res_reg, sk_res_reg;

    always_comb begin
        ax = eval(x_word);
        ay = eval(y_word);
        if (x_word.zero) begin
            res_next.outcome = segx_pkg::OUT_PARALLEL;
            res_next.cross_x = '0;
            res_next.cross_y = '0;
        end else begin
            res_next.outcome = (ax.good && ay.good) ? segx_pkg::OUT_HIT : segx_pkg::OUT_MISS;
            res_next.cross_x = ax.val;
            res_next.cross_y = ay.val;
        end
    end

    assign in_valid = x_valid && y_valid;
    assign en       = !sk_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            m_valid_reg  <= sk_valid_reg || in_valid;
            sk_valid_reg <= 1'b0;
        end else if (in_valid && en) begin
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !m_valid_reg) begin
            m_res_reg <= sk_valid_reg ? sk_res_reg : res_next;
        end else if (in_valid && en) begin
            sk_res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

// ===== design/segment_intersection.sv =====
// Segment crossing unit. Takes two line segments (start and end points, signed
// integer coordinates) and reports where the lines carrying them cross, in signed
// Q16.16 truncated toward zero, with an outcome code: crossing inside both
// segments' bounding boxes, lines crossing elsewhere, or parallel/collinear (point
// reported as zero). Points too large for 32 bits saturate. While s_tready is high
// the block takes one word per cycle and returns one result word per input word,
// in order. The path holds 38 register stages: five front stages for products and
// numerators, one stage per quotient bit in the two parallel 32-stage restoring
// dividers, and the output register. A stalled master side fills one skid word;
// only then does s_tready drop. Depends on segx_pkg.
module segment_intersection (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y (16 bits each)
    input  logic [segx_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cross_x [31:0], cross_y [63:32]
    output logic [segx_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // outcome [1:0]
    output logic [segx_pkg::OUT_TUSER_W-1:0]   m_tuser
);

    logic            en;
    logic            f_valid;
    segx_pkg::divw_t f_x, f_y;
    logic            dx_valid, dy_valid;
    segx_pkg::divw_t dx_word, dy_word;
    segx_pkg::res_t  res;

    // Products, denominator, numerators and divider setup.
    segx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s_valid   (s_tvalid),
        .s_data    (s_tdata),
        .out_valid (f_valid),
        .x_out     (f_x),
        .y_out     (f_y)
    );

    // Divide each numerator by the denominator, one axis per unit.
    segx_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_word   (f_x),
        .out_valid (dx_valid),
        .out_word  (dx_word)
    );

    segx_div u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_word   (f_y),
        .out_valid (dy_valid),
        .out_word  (dy_word)
    );

    // Range and box checks, saturation, output word and skid word.
    segx_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .x_valid (dx_valid),
        .x_word  (dx_word),
        .y_valid (dy_valid),
        .y_word  (dy_word),
        .en      (en),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    // The whole pipeline advances while the skid word is free.
    assign s_tready = en;
    assign m_tdata  = {res.cross_y, res.cross_x};
    assign m_tuser  = res.outcome;

endmodule

// ===== design/segx_checker.sv =====
// Port-level checks for the segment crossing unit, bound to the top level.
// Uses segx_pkg and segment_intersection_macros.svh.
`include "segment_intersection_macros.svh"

module segx_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [segx_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [segx_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [segx_pkg::OUT_TUSER_W-1:0]  m_tuser
);

    `SEGX_ASSERT(a_par_zero, m_tvalid && m_tuser == segx_pkg::OUT_PARALLEL |-> m_tdata == '0, "parallel result carries a nonzero point")
    `SEGX_ASSERT(a_hit_unsat, m_tvalid && m_tuser == segx_pkg::OUT_HIT |-> m_tdata[31:0] != 32'h7FFFFFFF && m_tdata[63:32] != 32'h7FFFFFFF, "hit with saturated point")
    `SEGX_ASSERT(a_skid_cause, !s_tready |-> $past(m_tvalid && !m_tready), "input stalled without a stalled output word")
    `SEGX_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")
    `SEGX_ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid, "output valid right after reset")

endmodule

bind segment_intersection segx_checker u_segx_checker (.*);
